@@ hdl/tipe_pkg.sv @@
// Shared types, constants and beat layouts for the toy ISA execute core.
package tipe_pkg;

	localparam int DATA_DEPTH = 256;
	localparam int DATA_AW    = $clog2(DATA_DEPTH);
	localparam int REG_COUNT  = 16;
	localparam int REG_AW     = $clog2(REG_COUNT);

	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 2;

	// input tdata layout
	localparam int IN_OFS_INSTR = 0;
	localparam int IN_OFS_PC    = 16;
	localparam int IN_OFS_TGT   = 24;
	localparam int IN_OFS_VAL   = 32;

	// output tdata layout
	localparam int OFS_NEXT_PC    = 0;
	localparam int OFS_HALTED     = 8;
	localparam int OFS_REG_NUMBER = 9;
	localparam int OFS_REG_VALUE  = 13;
	localparam int OFS_STORE_ADDR = 21;
	localparam int OFS_STORE_VAL  = 29;
	localparam int OFS_READ_DATA  = 37;
	localparam int OUT_PAD_W      = 3;

	// output tuser layout
	localparam int USR_REG_WRITE = 0;
	localparam int USR_STORE     = 1;

	typedef enum logic [1:0] {
		CMD_EXEC,
		CMD_SET_REG,
		CMD_WRITE_MEM,
		CMD_READ_MEM
	} cmd_t;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_INC,
		OP_AND,
		OP_OR,
		OP_XOR,
		OP_NOT,
		OP_SHL,
		OP_SRA,
		OP_LI,
		OP_LOAD,
		OP_STORE,
		OP_JUMP,
		OP_BEQZ,
		OP_HALT
	} op_t;

	typedef struct packed {
		logic [7:0]        next_pc;
		logic              halted;
		logic              reg_wr;
		logic [REG_AW-1:0] reg_num;
		logic [7:0]        reg_val;
		logic              is_load;
		logic              is_read;
		logic              store;
		logic [7:0]        store_addr;
		logic [7:0]        store_val;
	} res_t;

	function automatic logic [7:0] sext_nib(input logic [3:0] n);
		return {{4{n[3]}}, n};
	endfunction

	function automatic logic addr_ok(input logic [7:0] a);
		return ({1'b0, a} < 9'(DATA_DEPTH));
	endfunction

endpackage

@@ hdl/toy_isa_processor_execute.sv @@
// Top level of the toy ISA execute core: register file, data memory and pipeline.
// Each input beat is one instruction or one preload/readback command and yields
// exactly one result beat, in order. The core sustains one beat per cycle while the
// output is not held off. The register file is read at the accepting edge, the data
// memory as the beat moves into stage 2, and then the beat enters the result register;
// it waits longer only while the output is held off. Register results are forwarded,
// so dependent instructions follow each other with no gaps. s_axis_tready follows
// m_axis_tready through the stage enables. The register file reads as zero after reset.
module toy_isa_processor_execute
	import tipe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// instruction[15:0], pc[23:16], target_index[31:24], load_value[39:32]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// next_pc[7:0], halted[8], reg_number[12:9], reg_value[20:13],
	// store_address[28:21], store_value[36:29], read_data[44:37], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// reg_write_valid[0], store_valid[1]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	// stage enables
	logic out_en, s2_en, s1_en, s1_go;

	// stage 1
	logic        s1_v_s1;
	cmd_t        cmd_s1;
	logic [15:0] instr_s1;
	logic [7:0]  pc_s1, tgt_s1, lv_s1;

	// stage 2
	logic s2_v_s2;
	res_t res_s2;

	// output register
	logic                   m_v_q;
	logic [OUT_TDATA_W-1:0] tdata_q;
	logic [OUT_TUSER_W-1:0] tuser_q;

	// register file
	logic [7:0]          rf_a_q [REG_COUNT];
	logic [7:0]          rf_b_q [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [REG_AW-1:0]   rd_addr, rs1_addr, rs2_addr;
	logic [7:0]          rd_mem_q, rs1_mem_q, rs2_mem_q;
	logic                rd_vld_q, rs1_vld_q, rs2_vld_q;
	logic                we;
	logic [REG_AW-1:0]   wnum;
	logic [7:0]          wval;
	logic                lw_v_q;
	logic [REG_AW-1:0]   lw_num_q;
	logic [7:0]          lw_val_q;

	// data memory
	logic [7:0] data_mem_q [DATA_DEPTH];
	logic [7:0] dm_rdata_q;
	logic [7:0] dm_addr;

	// architectural halt
	logic halt_q;

	// stage 1 datapath
	op_t         op;
	logic [3:0]  f1, f2, f3;
	logic [7:0]  rd_val, ra, rb, ea, sra_res;
	logic [15:0] prod;
	logic        halt_set;
	res_t        r;

	assign out_en        = !m_v_q || m_axis_tready;
	assign s2_en         = !s2_v_s2 || out_en;
	assign s1_en         = !s1_v_s1 || s2_en;
	assign s1_go         = s1_v_s1 && s2_en;
	assign s_axis_tready = s1_en;

	assign m_axis_tvalid = m_v_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

	// register file write at stage 2 exit
	assign we   = s2_v_s2 && out_en && res_s2.reg_wr;
	assign wnum = res_s2.reg_num;
	assign wval = res_s2.is_load ? dm_rdata_q : res_s2.reg_val;

	// re-read every cycle for the item that will sit in stage 1
	always_comb begin
		if (s1_en) begin
			rd_addr  = s_axis_tdata[IN_OFS_INSTR+8 +: REG_AW];
			rs1_addr = s_axis_tdata[IN_OFS_INSTR+4 +: REG_AW];
			rs2_addr = s_axis_tdata[IN_OFS_INSTR +: REG_AW];
		end else begin
			rd_addr  = instr_s1[8 +: REG_AW];
			rs1_addr = instr_s1[4 +: REG_AW];
			rs2_addr = instr_s1[0 +: REG_AW];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rf_a_q[wnum] <= wval;
			rf_b_q[wnum] <= wval;
		end
		rs1_mem_q <= rf_a_q[rs1_addr];
		rs2_mem_q <= rf_a_q[rs2_addr];
		rd_mem_q  <= rf_b_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			rd_vld_q  <= 1'b0;
			rs1_vld_q <= 1'b0;
			rs2_vld_q <= 1'b0;
			lw_v_q    <= 1'b0;
		end else begin
			if (we) begin
				rf_vld_q[wnum] <= 1'b1;
			end
			rd_vld_q  <= rf_vld_q[rd_addr];
			rs1_vld_q <= rf_vld_q[rs1_addr];
			rs2_vld_q <= rf_vld_q[rs2_addr];
			lw_v_q    <= we;
		end
	end

	always_ff @(posedge clk) begin
		lw_num_q <= wnum;
		lw_val_q <= wval;
	end

	function automatic logic [7:0] fwd(
		input logic [REG_AW-1:0] n,
		input logic [7:0]        mem_val,
		input logic              mem_vld,
		input logic              s2_hit,
		input logic [REG_AW-1:0] s2_num,
		input logic [7:0]        s2_val,
		input logic              lw_hit,
		input logic [REG_AW-1:0] lw_num,
		input logic [7:0]        lw_val
	);
		if (s2_hit && s2_num == n) begin
			return s2_val;
		end
		if (lw_hit && lw_num == n) begin
			return lw_val;
		end
		return mem_vld ? mem_val : 8'h00;
	endfunction

	assign op = op_t'(instr_s1[15:12]);
	assign f1 = instr_s1[11:8];
	assign f2 = instr_s1[7:4];
	assign f3 = instr_s1[3:0];

	assign rd_val = fwd(f1, rd_mem_q, rd_vld_q, s2_v_s2 && res_s2.reg_wr, wnum, wval,
		lw_v_q, lw_num_q, lw_val_q);
	assign ra = fwd(f2, rs1_mem_q, rs1_vld_q, s2_v_s2 && res_s2.reg_wr, wnum, wval,
		lw_v_q, lw_num_q, lw_val_q);
	assign rb = fwd(f3, rs2_mem_q, rs2_vld_q, s2_v_s2 && res_s2.reg_wr, wnum, wval,
		lw_v_q, lw_num_q, lw_val_q);

	assign ea      = ra + sext_nib(f3);
	assign prod    = ra * rb;
	assign sra_res = 8'($signed(ra) >>> rb[2:0]);

	always_comb begin
		r          = '0;
		r.next_pc  = pc_s1;
		r.halted   = halt_q;
		dm_addr    = tgt_s1;
		halt_set   = 1'b0;
		case (cmd_s1)
			CMD_SET_REG: begin
				r.reg_wr  = 1'b1;
				r.reg_num = tgt_s1[REG_AW-1:0];
				r.reg_val = lv_s1;
			end
			CMD_WRITE_MEM: begin
				if (addr_ok(tgt_s1)) begin
					r.store      = 1'b1;
					r.store_addr = tgt_s1;
					r.store_val  = lv_s1;
				end
			end
			CMD_READ_MEM: begin
				r.is_read = addr_ok(tgt_s1);
			end
			CMD_EXEC: begin
				if (!halt_q) begin
					r.next_pc = pc_s1 + 8'd1;
					r.reg_wr  = (instr_s1[15:12] <= OP_LOAD);
					r.reg_num = f1;
					case (op)
						OP_ADD:  r.reg_val = ra + rb;
						OP_SUB:  r.reg_val = ra - rb;
						OP_MUL:  r.reg_val = prod[7:0];
						OP_INC:  r.reg_val = rd_val + 8'd1;
						OP_AND:  r.reg_val = ra & rb;
						OP_OR:   r.reg_val = ra | rb;
						OP_XOR:  r.reg_val = ra ^ rb;
						OP_NOT:  r.reg_val = ~ra;
						OP_SHL:  r.reg_val = (rb >= 8'd8) ? 8'h00 : 8'(ra << rb[2:0]);
						OP_SRA:  r.reg_val = (rb >= 8'd8) ? {8{ra[7]}} : sra_res;
						OP_LI:   r.reg_val = {f2, f3};
						OP_LOAD: begin
							r.is_load = addr_ok(ea);
							dm_addr   = ea;
						end
						OP_STORE: begin
							if (addr_ok(ea)) begin
								r.store      = 1'b1;
								r.store_addr = ea;
								r.store_val  = rd_val;
							end
						end
						OP_JUMP: r.next_pc = pc_s1 + {f1, f2};
						OP_BEQZ: begin
							if (rd_val == 8'h00) begin
								r.next_pc = pc_s1 + {f2, f3};
							end
						end
						OP_HALT: begin
							halt_set  = 1'b1;
							r.halted  = 1'b1;
							r.next_pc = pc_s1;
						end
						default: ;
					endcase
					if (!r.reg_wr) begin
						r.reg_num = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// data memory: stores and reads in program order at stage 1 exit
	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (r.store) begin
				data_mem_q[r.store_addr[DATA_AW-1:0]] <= r.store_val;
			end
			dm_rdata_q <= data_mem_q[dm_addr[DATA_AW-1:0]];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			s2_v_s2 <= 1'b0;
			m_v_q   <= 1'b0;
			halt_q  <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_v_s1 <= s_axis_tvalid;
			end
			if (s2_en) begin
				s2_v_s2 <= s1_v_s1;
			end
			if (out_en) begin
				m_v_q <= s2_v_s2;
			end
			if (s1_go && halt_set) begin
				halt_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s1_en && s_axis_tvalid) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			instr_s1 <= s_axis_tdata[IN_OFS_INSTR +: 16];
			pc_s1    <= s_axis_tdata[IN_OFS_PC +: 8];
			tgt_s1   <= s_axis_tdata[IN_OFS_TGT +: 8];
			lv_s1    <= s_axis_tdata[IN_OFS_VAL +: 8];
		end
		if (s1_go) begin
			res_s2 <= r;
		end
		if (out_en && s2_v_s2) begin
			tdata_q <= {
				{OUT_PAD_W{1'b0}},
				res_s2.is_read ? dm_rdata_q : 8'h00,
				res_s2.store_val,
				res_s2.store_addr,
				wval,
				res_s2.reg_num,
				res_s2.halted,
				res_s2.next_pc
			};
			tuser_q <= {res_s2.store, res_s2.reg_wr};
		end
	end

endmodule

@@ hdl/tipe_checker.sv @@
// Port-level checker for the toy ISA execute core, bound to the top level.
module tipe_checker
	import tipe_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	logic halt_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[OFS_HALTED]) begin
			halt_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && halt_seen_q |-> m_axis_tdata[OFS_HALTED])
		else $error("halt flag cleared after a halted beat");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[USR_REG_WRITE] && m_axis_tuser[USR_STORE]))
		else $error("beat both writes a register and stores");

	a_reg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[USR_REG_WRITE] |->
			m_axis_tdata[OFS_REG_NUMBER +: 4] == 4'h0 &&
			m_axis_tdata[OFS_REG_VALUE +: 8] == 8'h00)
		else $error("register fields set without a register write");

endmodule

bind toy_isa_processor_execute tipe_checker u_tipe_checker (.*);
